// ----- hw/rtl/fpa_pkg.sv -----
package fpa_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int DIV_W     = WORD_W + FRAC_BITS;
    localparam int DIV_STEPS = DIV_W;
    localparam int PROD_W    = 2 * WORD_W;

    localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_NEG   = 3'd4,
        OP_TRUNC = 3'd5
    } t_op;

    // One pipeline slot as it travels through the divider stages.
    typedef struct packed {
        logic              valid;
        logic [2:0]        kind;
        logic [WORD_W-1:0] value;
        logic              sat;
        logic              dz;
        logic              lt;
        logic              eq;
        logic              gt;
        logic              neg;
        logic [WORD_W-1:0] rem;
        logic [DIV_W-1:0]  work;
        logic [WORD_W-1:0] den;
    } t_slot;

endpackage

// ----- hw/rtl/q16_16_fixed_point_alu.sv -----
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_stall   i_kind, i_operand_a, i_operand_b
// result    out        o_valid / i_stall   o_value, o_saturated, o_divide_by_zero,
//                                          o_a_less, o_a_equal, o_a_greater
//
// Every operation passes from input transfer to result through three front stages,
// one stage per quotient bit of the 48-bit restoring divider, and the output register.
// One item is accepted per cycle while the result side keeps taking results.
// Reset is synchronous and clears all valid bits; payload registers are not reset, except in the divider stages.
// When a held result is stalled the whole pipeline freezes and o_stall is raised.
module q16_16_fixed_point_alu (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [2:0]                        i_kind,
    input  logic signed [fpa_pkg::WORD_W-1:0] i_operand_a,
    input  logic signed [fpa_pkg::WORD_W-1:0] i_operand_b,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [fpa_pkg::WORD_W-1:0] o_value,
    output logic                              o_saturated,
    output logic                              o_divide_by_zero,
    output logic                              o_a_less,
    output logic                              o_a_equal,
    output logic                              o_a_greater
);

    logic           adv;
    fpa_pkg::t_slot chain [0:fpa_pkg::DIV_STEPS];

    assign o_stall = !adv;

    fpa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_valid     (i_valid),
        .i_kind      (i_kind),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_slot      (chain[0])
    );

    for (genvar g = 0; g < fpa_pkg::DIV_STEPS; g++) begin : g_div
        fpa_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_slot  (chain[g]),
            .o_slot  (chain[g+1])
        );
    end

    fpa_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_slot           (chain[fpa_pkg::DIV_STEPS]),
        .i_stall          (i_stall),
        .o_adv            (adv),
        .o_valid          (o_valid),
        .o_value          (o_value),
        .o_saturated      (o_saturated),
        .o_divide_by_zero (o_divide_by_zero),
        .o_a_less         (o_a_less),
        .o_a_equal        (o_a_equal),
        .o_a_greater      (o_a_greater)
    );

endmodule

// ----- hw/rtl/fpa_front.sv -----
module fpa_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_adv,
    input  logic                               i_valid,
    input  logic [2:0]                         i_kind,
    input  logic signed [fpa_pkg::WORD_W-1:0]  i_operand_a,
    input  logic signed [fpa_pkg::WORD_W-1:0]  i_operand_b,
    output fpa_pkg::t_slot                     o_slot
);

    // Stage 1: input registers.
    logic                              r1_valid;
    logic [2:0]                        r1_kind;
    logic signed [fpa_pkg::WORD_W-1:0] r1_a;
    logic signed [fpa_pkg::WORD_W-1:0] r1_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_valid;
        end
        if (i_adv) begin
            r1_kind <= i_kind;
            r1_a    <= i_operand_a;
            r1_b    <= i_operand_b;
        end
    end

    // Stage 2: add/sub/neg/trunc results, compare flags, product, divider setup.
    logic signed [fpa_pkg::WORD_W:0]       sum;
    logic signed [fpa_pkg::WORD_W:0]       diff;
    logic [fpa_pkg::WORD_W-1:0]            abs_a;
    logic [fpa_pkg::WORD_W-1:0]            abs_b;
    logic [fpa_pkg::WORD_W-1:0]            n_value;
    logic                                  n_sat;
    logic                                  n_dz;
    logic signed [fpa_pkg::PROD_W-1:0]     n_prod;
    logic [fpa_pkg::DIV_W-1:0]             n_work;

    always_comb begin
        sum     = {r1_a[fpa_pkg::WORD_W-1], r1_a} + {r1_b[fpa_pkg::WORD_W-1], r1_b};
        diff    = {r1_a[fpa_pkg::WORD_W-1], r1_a} - {r1_b[fpa_pkg::WORD_W-1], r1_b};
        abs_a   = r1_a[fpa_pkg::WORD_W-1] ? (~r1_a + 1'b1) : r1_a;
        abs_b   = r1_b[fpa_pkg::WORD_W-1] ? (~r1_b + 1'b1) : r1_b;
        n_prod  = r1_a * r1_b;
        // Rounding the magnitude quotient up at one half gives round half away from zero.
        n_work  = {abs_a, {fpa_pkg::FRAC_BITS{1'b0}}}
                + fpa_pkg::DIV_W'(abs_b >> 1);
        n_value = '0;
        n_sat   = 1'b0;
        n_dz    = 1'b0;
        case (r1_kind)
            fpa_pkg::OP_ADD: begin
                if (sum[fpa_pkg::WORD_W] != sum[fpa_pkg::WORD_W-1]) begin
                    n_sat   = 1'b1;
                    n_value = sum[fpa_pkg::WORD_W] ? fpa_pkg::WORD_MIN : fpa_pkg::WORD_MAX;
                end else begin
                    n_value = sum[fpa_pkg::WORD_W-1:0];
                end
            end
            fpa_pkg::OP_SUB: begin
                if (diff[fpa_pkg::WORD_W] != diff[fpa_pkg::WORD_W-1]) begin
                    n_sat   = 1'b1;
                    n_value = diff[fpa_pkg::WORD_W] ? fpa_pkg::WORD_MIN : fpa_pkg::WORD_MAX;
                end else begin
                    n_value = diff[fpa_pkg::WORD_W-1:0];
                end
            end
            fpa_pkg::OP_DIV: begin
                if (r1_b == '0) begin
                    n_dz    = 1'b1;
                    n_value = r1_a[fpa_pkg::WORD_W-1] ? fpa_pkg::WORD_MIN : fpa_pkg::WORD_MAX;
                end
            end
            fpa_pkg::OP_NEG:   n_value = ~r1_a + 1'b1;
            fpa_pkg::OP_TRUNC: n_value = {r1_a[fpa_pkg::WORD_W-1:fpa_pkg::FRAC_BITS],
                                          {fpa_pkg::FRAC_BITS{1'b0}}};
            default:           n_value = '0;
        endcase
    end

    logic                              r2_valid;
    logic [2:0]                        r2_kind;
    logic [fpa_pkg::WORD_W-1:0]        r2_value;
    logic                              r2_sat;
    logic                              r2_dz;
    logic                              r2_lt;
    logic                              r2_eq;
    logic                              r2_gt;
    logic                              r2_neg;
    logic signed [fpa_pkg::PROD_W-1:0] r2_prod;
    logic [fpa_pkg::DIV_W-1:0]         r2_work;
    logic [fpa_pkg::WORD_W-1:0]        r2_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_adv) begin
            r2_valid <= r1_valid;
        end
        if (i_adv) begin
            r2_kind  <= r1_kind;
            r2_value <= n_value;
            r2_sat   <= n_sat;
            r2_dz    <= n_dz;
            r2_lt    <= r1_a < r1_b;
            r2_eq    <= r1_a == r1_b;
            r2_gt    <= r1_a > r1_b;
            r2_neg   <= r1_a[fpa_pkg::WORD_W-1] ^ r1_b[fpa_pkg::WORD_W-1];
            r2_prod  <= n_prod;
            r2_work  <= n_work;
            r2_den   <= abs_b;
        end
    end

    // Stage 3: multiply rounding, shift and clamp.
    logic signed [fpa_pkg::PROD_W-1:0] rnd;
    logic signed [fpa_pkg::PROD_W-1:0] shifted;
    fpa_pkg::t_slot                    n_slot;

    always_comb begin
        rnd     = r2_prod + (fpa_pkg::PROD_W'(1) << (fpa_pkg::FRAC_BITS - 1));
        shifted = rnd >>> fpa_pkg::FRAC_BITS;
        n_slot        = '0;
        n_slot.valid  = r2_valid;
        n_slot.kind   = r2_kind;
        n_slot.value  = r2_value;
        n_slot.sat    = r2_sat;
        n_slot.dz     = r2_dz;
        n_slot.lt     = r2_lt;
        n_slot.eq     = r2_eq;
        n_slot.gt     = r2_gt;
        n_slot.neg    = r2_neg;
        n_slot.work   = r2_work;
        n_slot.den    = r2_den;
        if (r2_kind == fpa_pkg::OP_MUL) begin
            if (shifted > $signed(fpa_pkg::PROD_W'({1'b0, fpa_pkg::WORD_MAX}))) begin
                n_slot.sat   = 1'b1;
                n_slot.value = fpa_pkg::WORD_MAX;
            end else if (shifted < -$signed(fpa_pkg::PROD_W'({1'b0, fpa_pkg::WORD_MIN}))) begin
                n_slot.sat   = 1'b1;
                n_slot.value = fpa_pkg::WORD_MIN;
            end else begin
                n_slot.value = shifted[fpa_pkg::WORD_W-1:0];
            end
        end
    end

    fpa_pkg::t_slot r3_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_slot.valid <= 1'b0;
        end else if (i_adv) begin
            r3_slot.valid <= n_slot.valid;
        end
        if (i_adv) begin
            r3_slot.kind  <= n_slot.kind;
            r3_slot.value <= n_slot.value;
            r3_slot.sat   <= n_slot.sat;
            r3_slot.dz    <= n_slot.dz;
            r3_slot.lt    <= n_slot.lt;
            r3_slot.eq    <= n_slot.eq;
            r3_slot.gt    <= n_slot.gt;
            r3_slot.neg   <= n_slot.neg;
            r3_slot.rem   <= n_slot.rem;
            r3_slot.work  <= n_slot.work;
            r3_slot.den   <= n_slot.den;
        end
    end

    assign o_slot = r3_slot;

endmodule

// ----- hw/rtl/fpa_div_step.sv -----
module fpa_div_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  fpa_pkg::t_slot i_slot,
    output fpa_pkg::t_slot o_slot
);

    logic [fpa_pkg::WORD_W:0] trial;
    logic [fpa_pkg::WORD_W:0] trial_sub;
    fpa_pkg::t_slot           n_slot;

    // One restoring step: bring down the next dividend bit, subtract if it fits.
    always_comb begin
        trial     = {i_slot.rem, i_slot.work[fpa_pkg::DIV_W-1]};
        trial_sub = trial - {1'b0, i_slot.den};
        n_slot    = i_slot;
        if (trial >= {1'b0, i_slot.den}) begin
            n_slot.rem  = trial_sub[fpa_pkg::WORD_W-1:0];
            n_slot.work = {i_slot.work[fpa_pkg::DIV_W-2:0], 1'b1};
        end else begin
            n_slot.rem  = trial[fpa_pkg::WORD_W-1:0];
            n_slot.work = {i_slot.work[fpa_pkg::DIV_W-2:0], 1'b0};
        end
    end

    fpa_pkg::t_slot r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (i_adv) begin
            r_slot <= n_slot;
        end
    end

    assign o_slot = r_slot;

endmodule

// ----- hw/rtl/fpa_back.sv -----
module fpa_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fpa_pkg::t_slot                    i_slot,
    input  logic                              i_stall,
    output logic                              o_adv,
    output logic                              o_valid,
    output logic signed [fpa_pkg::WORD_W-1:0] o_value,
    output logic                              o_saturated,
    output logic                              o_divide_by_zero,
    output logic                              o_a_less,
    output logic                              o_a_equal,
    output logic                              o_a_greater
);

    logic [fpa_pkg::DIV_W-1:0]  q;
    logic [fpa_pkg::WORD_W-1:0] n_value;
    logic                       n_sat;

    // After the last step the work register holds the magnitude quotient.
    always_comb begin
        q       = i_slot.work;
        n_value = i_slot.value;
        n_sat   = i_slot.sat;
        if (i_slot.kind == fpa_pkg::OP_DIV && !i_slot.dz) begin
            if (i_slot.neg) begin
                if (q > fpa_pkg::DIV_W'(fpa_pkg::WORD_MIN)) begin
                    n_sat   = 1'b1;
                    n_value = fpa_pkg::WORD_MIN;
                end else begin
                    n_value = ~q[fpa_pkg::WORD_W-1:0] + 1'b1;
                end
            end else begin
                if (q > fpa_pkg::DIV_W'(fpa_pkg::WORD_MAX)) begin
                    n_sat   = 1'b1;
                    n_value = fpa_pkg::WORD_MAX;
                end else begin
                    n_value = q[fpa_pkg::WORD_W-1:0];
                end
            end
        end
    end

    logic r_valid;

    assign o_adv = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_slot.valid;
        end
        if (o_adv) begin
            o_value          <= n_value;
            o_saturated      <= n_sat;
            o_divide_by_zero <= i_slot.dz;
            o_a_less         <= i_slot.lt;
            o_a_equal        <= i_slot.eq;
            o_a_greater      <= i_slot.gt;
        end
    end

    assign o_valid = r_valid;

endmodule

// ----- hw/rtl/fpa_checker.sv -----
module fpa_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic signed [fpa_pkg::WORD_W-1:0] o_value,
    input logic                              o_saturated,
    input logic                              o_divide_by_zero,
    input logic                              o_a_less,
    input logic                              o_a_equal,
    input logic                              o_a_greater
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value))
        else $error("stalled result changed");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones({o_a_less, o_a_equal, o_a_greater}) == 1)
        else $error("compare flags not exactly one");

    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_by_zero |-> !o_saturated)
        else $error("divide by zero also flagged saturated");

    a_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("input taken while output held");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");

endmodule

bind q16_16_fixed_point_alu fpa_checker u_fpa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_value          (o_value),
    .o_saturated      (o_saturated),
    .o_divide_by_zero (o_divide_by_zero),
    .o_a_less         (o_a_less),
    .o_a_equal        (o_a_equal),
    .o_a_greater      (o_a_greater)
);
